// ===== rtl/core/hsi_pkg.sv =====
`default_nettype none
package hsi_pkg;

   localparam int ANG_BITS         = 24;
   localparam int CORDIC_STEPS     = 22;
   localparam int DIV_STEPS        = 8;
   localparam int HUE_BITS_DEFAULT = 12;
   localparam int XY_W             = 29;
   localparam int NUM_W            = 19;
   localparam int DEN_W            = 11;
   localparam int SUM_W            = 10;
   localparam logic [16:0] SQRT3_Q16 = 17'd113512;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic [ANG_BITS-1:0]    z;
      logic                   gray;
      logic                   dark;
      logic [NUM_W-1:0]       num;
      logic [DEN_W-1:0]       den;
      logic [DIV_STEPS-1:0]   quo;
      logic [7:0]             inten;
   } hsi_data_type;

   // atan(2^-i) in turns, 2^24 steps per turn
   function automatic logic [ANG_BITS-1:0] atan_turn(input int i);
      logic [ANG_BITS-1:0] a;
      case (i)
         0:  a = 24'd2097152;
         1:  a = 24'd1238021;
         2:  a = 24'd654136;
         3:  a = 24'd332050;
         4:  a = 24'd166669;
         5:  a = 24'd83416;
         6:  a = 24'd41718;
         7:  a = 24'd20860;
         8:  a = 24'd10430;
         9:  a = 24'd5215;
         10: a = 24'd2608;
         11: a = 24'd1304;
         12: a = 24'd652;
         13: a = 24'd326;
         14: a = 24'd163;
         15: a = 24'd81;
         16: a = 24'd41;
         17: a = 24'd20;
         18: a = 24'd10;
         19: a = 24'd5;
         20: a = 24'd3;
         21: a = 24'd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hsi_prep.sv =====
`default_nettype none
module hsi_prep (
   input  wire logic                clock,
   input  wire logic [7:0]          blue,
   input  wire logic [7:0]          green,
   input  wire logic [7:0]          red,
   output hsi_pkg::hsi_data_type    d_out
);
   import hsi_pkg::*;

   hsi_data_type d_in, d_ff;
   logic [SUM_W-1:0]        sum;
   logic [7:0]              mn;
   logic [SUM_W-1:0]        spread;
   logic signed [10:0]      xd;
   logic signed [9:0]       yd;
   logic signed [XY_W-1:0]  x0, y0;
   logic [SUM_W+10:0]       inten_prod;

   always_comb begin
      sum = SUM_W'(blue) + SUM_W'(green) + SUM_W'(red);
      mn  = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      spread = sum - SUM_W'(3 * SUM_W'(mn));
      xd = 11'(signed'({3'b0, red}) * 2) - signed'({3'b0, green}) - signed'({3'b0, blue});
      yd = signed'({2'b0, green}) - signed'({2'b0, blue});
      x0 = XY_W'(xd) <<< 16;
      y0 = XY_W'(yd) * signed'({1'b0, SQRT3_Q16});
      // sum/3 by reciprocal, exact for sums up to 765
      inten_prod = (SUM_W+11)'(sum) * (SUM_W+11)'(683);

      d_in.gray  = (red == green) && (green == blue);
      d_in.dark  = (sum == '0);
      d_in.num   = NUM_W'(NUM_W'(spread) * NUM_W'(510)) + NUM_W'(sum);
      d_in.den   = {sum, 1'b0};
      d_in.quo   = '0;
      d_in.inten = inten_prod[18:11];
      if (xd < 0) begin
         d_in.x = -x0;
         d_in.y = -y0;
         d_in.z = ANG_BITS'(1) << (ANG_BITS - 1);
      end else begin
         d_in.x = x0;
         d_in.y = y0;
         d_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in;
   end

   assign d_out = d_ff;
endmodule
`default_nettype wire

// ===== rtl/core/hsi_cell.sv =====
`default_nettype none
module hsi_cell #(
   parameter int STEP = 0
) (
   input  wire logic                  clock,
   input  wire hsi_pkg::hsi_data_type d_in,
   output hsi_pkg::hsi_data_type      d_out
);
   import hsi_pkg::*;

   localparam int QB = (STEP < DIV_STEPS) ? DIV_STEPS - 1 - STEP : 0;

   hsi_data_type d_nx_in, d_ff;
   logic signed [XY_W-1:0] dx, dy;
   logic [NUM_W-1:0]       trial;

   always_comb begin
      d_nx_in = d_in;
      // shifts truncate toward zero
      dx = d_in.x[XY_W-1] ? -((-d_in.x) >>> STEP) : (d_in.x >>> STEP);
      dy = d_in.y[XY_W-1] ? -((-d_in.y) >>> STEP) : (d_in.y >>> STEP);
      if (!d_in.y[XY_W-1]) begin
         d_nx_in.x = d_in.x + dy;
         d_nx_in.y = d_in.y - dx;
         d_nx_in.z = d_in.z + atan_turn(STEP);
      end else begin
         d_nx_in.x = d_in.x - dy;
         d_nx_in.y = d_in.y + dx;
         d_nx_in.z = d_in.z - atan_turn(STEP);
      end
      // one restoring divide step for saturation in the first cells
      trial = NUM_W'(d_in.den) << QB;
      if (STEP < DIV_STEPS) begin
         if (d_in.num >= trial) begin
            d_nx_in.num     = d_in.num - trial;
            d_nx_in.quo[QB] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_nx_in;
   end

   assign d_out = d_ff;
endmodule
`default_nettype wire

// ===== rtl/core/rgb_to_hsi_pixel.sv =====
`default_nettype none
// RGB to HSI pixel converter.
// Input: pulse start with req_blue/req_green/req_red; busy is always low,
// so an item may be given on every clock.
// Output: rsp_valid strobes for one cycle with rsp_hue, rsp_saturation and
// rsp_intensity; the receiver must take it in that cycle.
// The pipe holds one preparation stage, a row of 22 CORDIC cells
// (the first 8 also resolve one saturation quotient bit each) and an output
// register. Throughput is one item per cycle, set by the cell row.
// Hue is atan2(sqrt(3)(G-B), 2R-G-B) in 2^HUE_BITS steps per turn, 0 for
// gray. Saturation is 0 for black. Intensity is the floor of the mean.
// Items leave in the order they enter; no state links pixels.
// Reset clears the valid pipe, so no strobe appears for items in flight.
module rgb_to_hsi_pixel #(
   parameter int HUE_BITS = hsi_pkg::HUE_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [7:0]          req_blue,
   input  wire logic [7:0]          req_green,
   input  wire logic [7:0]          req_red,
   output logic                     rsp_valid,
   output logic [HUE_BITS-1:0]      rsp_hue,
   output logic [7:0]               rsp_saturation,
   output logic [7:0]               rsp_intensity
);
   import hsi_pkg::*;

   localparam int DEPTH = CORDIC_STEPS + 2;

   hsi_data_type       chain [CORDIC_STEPS+1];
   logic [DEPTH-1:0]   valid_ff, valid_in;
   logic [ANG_BITS-1:0] z_round;
   logic [HUE_BITS-1:0] hue_ff, hue_in;
   logic [7:0]          sat_ff, sat_in, inten_ff;

   hsi_prep u_prep (
      .clock (clock),
      .blue  (req_blue),
      .green (req_green),
      .red   (req_red),
      .d_out (chain[0])
   );

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      hsi_cell #(.STEP(i)) u_cell (
         .clock (clock),
         .d_in  (chain[i]),
         .d_out (chain[i+1])
      );
   end

   always_comb begin
      valid_in = {valid_ff[DEPTH-2:0], start};
      z_round  = chain[CORDIC_STEPS].z + (ANG_BITS'(1) << (ANG_BITS - 1 - HUE_BITS));
      hue_in   = chain[CORDIC_STEPS].gray ? '0 : z_round[ANG_BITS-1 -: HUE_BITS];
      sat_in   = chain[CORDIC_STEPS].dark ? '0 : chain[CORDIC_STEPS].quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      hue_ff   <= hue_in;
      sat_ff   <= sat_in;
      inten_ff <= chain[CORDIC_STEPS].inten;
   end

   assign busy           = 1'b0;
   assign rsp_valid      = valid_ff[DEPTH-1];
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_intensity  = inten_ff;
endmodule
`default_nettype wire
